// File: hdl/leaq_pkg.sv
// Package for the loud event alert qualifier.
// Field widths, register indexes, mode codes and timing constants.
// No dependencies.
`timescale 1ns / 1ps

package leaq_pkg;

   // Transaction field widths
   localparam int LEVEL_W = 16;
   localparam int STAMP_W = 32;
   localparam int MODE_W  = 2;
   localparam int COUNT_W = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOUD_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_SEC    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_SEC     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOTIFY_EN      = 8'd3;

   // Detector mode codes
   localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RISING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd2;

   // Timing constants in ms
   localparam int GRACE_MS = 700;
   localparam int LATCH_MS = 120 * 1000;
   localparam int MS_PER_S = 1000;

   // 255 s in ms fits in 18 bits
   localparam int SEC_MS_W = 18;

   typedef logic [SEC_MS_W-1:0] sec_ms_type;

endpackage

// File: hdl/leaq_req_if.sv
// Input channel of the loud event alert qualifier: report or link-loss reset.
// Depends on leaq_pkg.
`timescale 1ns / 1ps

interface leaq_req_if
   import leaq_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [LEVEL_W-1:0] level_db;
   logic [STAMP_W-1:0] time_ms;

   modport source (output valid, cmd, level_db, time_ms, input ready);
   modport sink   (input valid, cmd, level_db, time_ms, output ready);
endinterface

// File: hdl/leaq_rsp_if.sv
// Result channel of the loud event alert qualifier.
// Depends on leaq_pkg.
`timescale 1ns / 1ps

interface leaq_rsp_if
   import leaq_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  detector_mode;
   logic               alert_flag;
   logic               alert_notify;
   logic               stop_notify;
   logic [COUNT_W-1:0] alert_count;

   modport source (output valid, detector_mode, alert_flag, alert_notify, stop_notify,
                   alert_count, input ready);
   modport sink   (input valid, detector_mode, alert_flag, alert_notify, stop_notify,
                   alert_count, output ready);
endinterface

// File: hdl/leaq_csr_if.sv
// Register write channel of the loud event alert qualifier.
// Depends on leaq_pkg.
`timescale 1ns / 1ps

interface leaq_csr_if
   import leaq_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/loud_event_alert_qualifier.sv
// Top level of the loud event alert qualifier: detector state machine,
// register file, input and result registers.
// Depends on leaq_pkg, leaq_req_if, leaq_rsp_if, leaq_csr_if.
//
// Usage:
//   req carries one transaction per sound-level report (cmd = 0, level_db,
//   time_ms) or a link-loss reset (cmd = 1). rsp returns exactly one
//   transaction per req transaction, in order: mode after the step, the
//   alert flag, alert/stop notify pulses and the alert count of the episode.
//   csr writes the threshold, confirm time, repeat time and notify enable;
//   it is always ready, and writes should be made while no transaction is
//   in flight. Second counts are converted to ms when written.
//   A result passes the input register, then the result register, after its
//   req transaction is accepted. One transaction is accepted every cycle
//   while rsp is not stalled; the detector state updates in one pass of
//   compares and subtracts per item.
//   If rsp is stalled, the result register holds and the input register
//   fills; req.ready then drops until rsp.ready returns.
//   Reset (synchronous, active high) empties both registers, returns the
//   detector to idle with all timestamps, flag and count at zero, and loads
//   the register defaults (75 dB, 2 s, 3 s, notify off).
`timescale 1ns / 1ps

module loud_event_alert_qualifier
   import leaq_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   leaq_req_if.sink   req,
   leaq_rsp_if.source rsp,
   leaq_csr_if.sink   csr
);

   localparam logic [TIME_BITS-1:0] GRACE_T = TIME_BITS'(GRACE_MS);
   localparam logic [TIME_BITS-1:0] LATCH_T = TIME_BITS'(LATCH_MS);

   // Registers
   logic [CSR_DATA_W-1:0] threshold_ff;
   sec_ms_type            confirm_ms_ff;
   sec_ms_type            repeat_ms_ff;
   logic                  notify_en_ff;

   // Input register
   logic               s1_valid_ff;
   logic               s1_cmd_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   logic [STAMP_W-1:0] s1_time_ff;

   // Detector state
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [TIME_BITS-1:0] rise_start_ff, rise_start_in;
   logic [TIME_BITS-1:0] last_loud_ff, last_loud_in;
   logic [TIME_BITS-1:0] last_alert_ff, last_alert_in;
   logic [TIME_BITS-1:0] episode_ff, episode_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 flag_ff, flag_in;

   // Result register
   logic              out_valid_ff;
   logic [MODE_W-1:0] out_mode_ff;
   logic              out_flag_ff;
   logic              out_alert_ff;
   logic              out_stop_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic                 s1_advance;
   logic                 loud;
   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] since_loud, since_rise, since_episode, since_alert;
   logic                 alert_now, stop_now;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign csr.ready  = 1'b1;

   // Register writes; seconds stored as ms
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= CSR_DATA_W'(75);
         confirm_ms_ff <= SEC_MS_W'(2 * MS_PER_S);
         repeat_ms_ff  <= SEC_MS_W'(3 * MS_PER_S);
         notify_en_ff  <= 1'b0;
      end else if (csr.valid) begin
         if (csr.index == REG_LOUD_THRESHOLD) begin
            threshold_ff <= csr.data;
         end
         if (csr.index == REG_CONFIRM_SEC) begin
            confirm_ms_ff <= SEC_MS_W'(csr.data) * SEC_MS_W'(MS_PER_S);
         end
         if (csr.index == REG_REPEAT_SEC) begin
            repeat_ms_ff <= SEC_MS_W'(csr.data) * SEC_MS_W'(MS_PER_S);
         end
         if (csr.index == REG_NOTIFY_EN) begin
            notify_en_ff <= csr.data[0];
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         s1_cmd_ff   <= req.cmd;
         s1_level_ff <= req.level_db;
         s1_time_ff  <= req.time_ms;
      end
   end

   // Negative levels are never loud
   assign loud = !s1_level_ff[LEVEL_W-1] &&
                 (s1_level_ff[LEVEL_W-2:0] >= (LEVEL_W-1)'(threshold_ff));
   assign now  = TIME_BITS'(s1_time_ff);

   assign since_loud    = now - last_loud_ff;
   assign since_rise    = now - rise_start_ff;
   assign since_episode = now - episode_ff;
   assign since_alert   = now - last_alert_ff;

   always_comb begin
      mode_in       = mode_ff;
      rise_start_in = rise_start_ff;
      last_loud_in  = last_loud_ff;
      last_alert_in = last_alert_ff;
      episode_in    = episode_ff;
      count_in      = count_ff;
      flag_in       = flag_ff;
      alert_now     = 1'b0;
      stop_now      = 1'b0;
      if (s1_cmd_ff) begin
         mode_in       = MODE_IDLE;
         rise_start_in = '0;
         last_loud_in  = '0;
         last_alert_in = '0;
         episode_in    = '0;
         count_in      = '0;
         flag_in       = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_RISING: begin
               if (loud) begin
                  last_loud_in = now;
               end
               if (!loud && (since_loud > GRACE_T)) begin
                  mode_in = MODE_IDLE;
               end else if (since_rise >= TIME_BITS'(confirm_ms_ff)) begin
                  episode_in    = now;
                  count_in      = COUNT_W'(1);
                  flag_in       = 1'b1;
                  alert_now     = notify_en_ff;
                  last_alert_in = now;
                  mode_in       = MODE_ACTIVE;
               end
            end
            MODE_ACTIVE: begin
               if (since_episode >= LATCH_T) begin
                  flag_in  = 1'b0;
                  stop_now = notify_en_ff;
                  mode_in  = MODE_IDLE;
                  count_in = '0;
               end else if (since_alert >= TIME_BITS'(repeat_ms_ff)) begin
                  count_in      = count_ff + COUNT_W'(1);
                  flag_in       = 1'b1;
                  alert_now     = notify_en_ff;
                  last_alert_in = now;
               end
            end
            default: begin
               // idle, and the unused code behaves as idle
               mode_in = MODE_IDLE;
               if (loud) begin
                  rise_start_in = now;
                  last_loud_in  = now;
                  mode_in       = MODE_RISING;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         rise_start_ff <= '0;
         last_loud_ff  <= '0;
         last_alert_ff <= '0;
         episode_ff    <= '0;
         count_ff      <= '0;
         flag_ff       <= 1'b0;
      end else if (s1_advance) begin
         mode_ff       <= mode_in;
         rise_start_ff <= rise_start_in;
         last_loud_ff  <= last_loud_in;
         last_alert_ff <= last_alert_in;
         episode_ff    <= episode_in;
         count_ff      <= count_in;
         flag_ff       <= flag_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_mode_ff  <= mode_in;
         out_flag_ff  <= flag_in;
         out_alert_ff <= alert_now;
         out_stop_ff  <= stop_now;
         out_count_ff <= count_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.detector_mode = out_mode_ff;
   assign rsp.alert_flag    = out_flag_ff;
   assign rsp.alert_notify  = out_alert_ff;
   assign rsp.stop_notify   = out_stop_ff;
   assign rsp.alert_count   = out_count_ff;

endmodule
